@@ hdl/diff_drive_odometry_defines.svh @@
// assertion macros for the checker file of the odometry block
// no dependencies; expects clk and arst_n in the scope of use
`ifndef DIFF_DRIVE_ODOMETRY_DEFINES_SVH
`define DIFF_DRIVE_ODOMETRY_DEFINES_SVH

// same-cycle implication
`define DDO_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ddo check failed");

// next-cycle implication
`define DDO_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ddo check failed");

`endif

@@ hdl/ddo_pkg.sv @@
// shared types, constants and helper functions of the odometry block
// no dependencies
package ddo_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);
	localparam int CFG_W        = 24;
	localparam int MUL_B_W      = 24;
	localparam int MUL_N_W      = 5;

	localparam logic REG_SPEED_PER_RPM = 1'b0;
	localparam logic REG_INVERSE_TRACK = 1'b1;

	localparam logic [CFG_W-1:0] SPEED_PER_RPM_RST = 24'd57980;
	localparam logic [CFG_W-1:0] INVERSE_TRACK_RST = 24'd409600;
	localparam logic [MUL_B_W-1:0] HEAD_SCALE      = 24'd683565;
	localparam logic [10:0] DIV_CONST              = 11'd1000;

	localparam logic [3:0] PH_SUMV  = 4'd0;
	localparam logic [3:0] PH_DIFV  = 4'd1;
	localparam logic [3:0] PH_OMEGA = 4'd2;
	localparam logic [3:0] PH_WDT   = 4'd3;
	localparam logic [3:0] PH_HEAD  = 4'd4;
	localparam logic [3:0] PH_ROT   = 4'd5;
	localparam logic [3:0] PH_VC    = 4'd6;
	localparam logic [3:0] PH_PX    = 4'd7;
	localparam logic [3:0] PH_DIVX  = 4'd8;
	localparam logic [3:0] PH_VS    = 4'd9;
	localparam logic [3:0] PH_PY    = 4'd10;
	localparam logic [3:0] PH_DIVY  = 4'd11;
	localparam logic [3:0] PH_QUAT  = 4'd12;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CALC = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	typedef struct packed {
		logic               start;
		logic               b_signed;
		logic [MUL_N_W-1:0] nbits;
	} mul_cmd_t;

	typedef struct packed {
		logic        start;
		logic [31:0] angle;
	} cordic_cmd_t;

	typedef struct packed {
		logic signed [15:0] c;
		logic signed [15:0] s;
	} sc_t;

	typedef struct packed {
		logic done;
		sc_t  val;
	} cordic_res_t;

	function automatic logic [29:0] atan_turn(input logic [4:0] i);
		logic [29:0] r;
		case (i)
			5'd0:  r = 30'd536870912;
			5'd1:  r = 30'd316933406;
			5'd2:  r = 30'd167458907;
			5'd3:  r = 30'd85004756;
			5'd4:  r = 30'd42667331;
			5'd5:  r = 30'd21354465;
			5'd6:  r = 30'd10679838;
			5'd7:  r = 30'd5340245;
			5'd8:  r = 30'd2670163;
			5'd9:  r = 30'd1335087;
			5'd10: r = 30'd667544;
			5'd11: r = 30'd333772;
			5'd12: r = 30'd166886;
			5'd13: r = 30'd83443;
			5'd14: r = 30'd41722;
			5'd15: r = 30'd20861;
			5'd16: r = 30'd10430;
			5'd17: r = 30'd5215;
			5'd18: r = 30'd2608;
			5'd19: r = 30'd1304;
			5'd20: r = 30'd652;
			5'd21: r = 30'd326;
			5'd22: r = 30'd163;
			5'd23: r = 30'd81;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
		logic signed [15:0] r;
		if (v > 48'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -48'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
		logic signed [31:0] r;
		if (v > 50'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -50'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [15:0] rnd_q15(input logic signed [33:0] x);
		logic signed [33:0] t;
		logic signed [15:0] r;
		t = (x + 34'sd16384) >>> 15;
		if (t > 34'sd32767) begin
			r = 16'sh7FFF;
		end else if (t < -34'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = t[15:0];
		end
		return r;
	endfunction

	function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
		logic signed [15:0] r;
		if (v == 16'sh8000) begin
			r = 16'sh7FFF;
		end else begin
			r = -v;
		end
		return r;
	endfunction

	function automatic sc_t quad_map(input logic [1:0] quad, input logic signed [15:0] qc,
			input logic signed [15:0] qs);
		sc_t r;
		case (quad)
			2'd0: begin
				r.c = qc;
				r.s = qs;
			end
			2'd1: begin
				r.c = neg_sat(qs);
				r.s = qc;
			end
			2'd2: begin
				r.c = neg_sat(qc);
				r.s = neg_sat(qs);
			end
			default: begin
				r.c = qs;
				r.s = neg_sat(qc);
			end
		endcase
		return r;
	endfunction

endpackage

@@ hdl/ddo_mul.sv @@
// bit-serial shift-add multiplier: signed multiplicand, multiplier one bit per cycle
// optional two's complement weight on the top multiplier bit; uses ddo_pkg
module ddo_mul (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ddo_pkg::mul_cmd_t                  cmd,
	input  logic signed [63:0]                 a,
	input  logic [ddo_pkg::MUL_B_W-1:0]        b,
	output logic                               done,
	output logic [63:0]                        prod
);

	logic                             busy_q;
	logic [ddo_pkg::MUL_N_W-1:0]      cnt_q;
	logic                             sgn_q;
	logic [63:0]                      a_q;
	logic [ddo_pkg::MUL_B_W-1:0]      b_q;
	logic [63:0]                      acc_q;
	logic                             neg_bit;

	assign neg_bit = sgn_q && (cnt_q == ddo_pkg::MUL_N_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			cnt_q  <= cmd.nbits;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - ddo_pkg::MUL_N_W'(1);
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sgn_q <= cmd.b_signed;
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q && (cnt_q != '0)) begin
			if (b_q[0]) begin
				acc_q <= neg_bit ? (acc_q - a_q) : (acc_q + a_q);
			end
			a_q <= {a_q[62:0], 1'b0};
			b_q <= {1'b0, b_q[ddo_pkg::MUL_B_W-1:1]};
		end
	end

	assign done = busy_q && (cnt_q == '0);
	assign prod = acc_q;

endmodule

@@ hdl/ddo_cordic.sv @@
// iterative rotation-mode cordic, one micro-rotation per cycle, Q4.30 data
// angle in 2^-32 turn, results as saturated Q1.15 cos and sin; uses ddo_pkg
module ddo_cordic (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ddo_pkg::cordic_cmd_t  cmd,
	output ddo_pkg::cordic_res_t  res
);

	logic                            busy_q;
	logic [ddo_pkg::STEP_W-1:0]      i_q;
	logic [1:0]                      quad_q;
	logic signed [33:0]              x_q;
	logic signed [33:0]              y_q;
	logic signed [32:0]              z_q;
	logic [31:0]                     t;
	logic signed [33:0]              xs;
	logic signed [33:0]              ys;
	logic signed [32:0]              at;
	logic                            dir;

	assign t   = cmd.angle + 32'h2000_0000;
	assign xs  = x_q >>> i_q;
	assign ys  = y_q >>> i_q;
	assign at  = $signed({3'b000, ddo_pkg::atan_turn(5'(i_q))});
	assign dir = !z_q[32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q    <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			i_q    <= '0;
		end else if (busy_q) begin
			if (i_q != ddo_pkg::STEP_W'(ddo_pkg::CORDIC_STEPS)) begin
				i_q <= i_q + ddo_pkg::STEP_W'(1);
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			quad_q <= t[31:30];
			x_q    <= 34'sd652032874;
			y_q    <= '0;
			z_q    <= $signed({3'b000, t[29:0]}) - 33'sd536870912;
		end else if (busy_q && (i_q != ddo_pkg::STEP_W'(ddo_pkg::CORDIC_STEPS))) begin
			x_q <= dir ? (x_q - ys) : (x_q + ys);
			y_q <= dir ? (y_q + xs) : (y_q - xs);
			z_q <= dir ? (z_q - at) : (z_q + at);
		end
	end

	assign res.done = busy_q && (i_q == ddo_pkg::STEP_W'(ddo_pkg::CORDIC_STEPS));
	assign res.val  = ddo_pkg::quad_map(quad_q, ddo_pkg::rnd_q15(x_q), ddo_pkg::rnd_q15(y_q));

endmodule

@@ hdl/diff_drive_odometry.sv @@
// differential-drive odometry: one transaction at a time, input stalled while busy
// the work is done by the bit-serial multiplier (one multiplier bit a cycle), the
// bit-serial divide by 1000 and the cordic, which is called twice per transaction
// reset: pose and heading cleared, registers at their defaults, no pass needed
// uses ddo_pkg, ddo_mul and ddo_cordic
module diff_drive_odometry (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [ddo_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [15:0]             left_speed,
	input  logic signed [15:0]             right_speed,
	input  logic [15:0]                    elapsed_ms,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [31:0]             pos_x,
	output logic signed [31:0]             pos_y,
	output logic [15:0]                    heading_out,
	output logic signed [15:0]             lin_vel,
	output logic signed [15:0]             ang_vel,
	output logic signed [15:0]             quat_z,
	output logic signed [15:0]             quat_w
);

	ddo_pkg::state_t               state_q;
	logic [3:0]                    ph_q;
	logic                          launch_q;
	logic [ddo_pkg::CFG_W-1:0]     sp_q;
	logic [ddo_pkg::CFG_W-1:0]     it_q;
	logic signed [16:0]            sum_q;
	logic signed [16:0]            dif_q;
	logic [15:0]                   dt_q;
	logic signed [29:0]            v16_q;
	logic signed [29:0]            dv_q;
	logic signed [39:0]            w_q;
	logic [47:0]                   wdt_q;
	logic [15:0]                   hd_q;
	logic signed [15:0]            c_q;
	logic signed [15:0]            s_q;
	logic signed [15:0]            lin_q;
	logic signed [15:0]            ang_q;
	logic signed [31:0]            acc_x_q;
	logic signed [31:0]            acc_y_q;
	logic signed [15:0]            qw_q;
	logic signed [15:0]            qz_q;

	logic                          div_busy_q;
	logic [5:0]                    div_cnt_q;
	logic [9:0]                    div_rem_q;
	logic [47:0]                   div_num_q;
	logic                          div_neg_q;

	logic                          out_valid_q;
	logic signed [31:0]            o_x_q;
	logic signed [31:0]            o_y_q;
	logic [15:0]                   o_hd_q;
	logic signed [15:0]            o_lin_q;
	logic signed [15:0]            o_ang_q;
	logic signed [15:0]            o_qz_q;
	logic signed [15:0]            o_qw_q;

	ddo_pkg::mul_cmd_t             mcmd;
	logic signed [63:0]            mul_a;
	logic [ddo_pkg::MUL_B_W-1:0]   mul_b;
	logic                          mul_done;
	logic [63:0]                   mul_prod;
	ddo_pkg::cordic_cmd_t          ccmd;
	ddo_pkg::cordic_res_t          cres;

	logic                          in_acc;
	logic                          is_cordic;
	logic                          is_div;
	logic                          div_start;
	logic                          div_done;
	logic                          unit_done;
	logic signed [63:0]            p_s;
	logic signed [63:0]            r_v16;
	logic signed [63:0]            r_lin;
	logic signed [63:0]            r_dv;
	logic signed [63:0]            r_w;
	logic signed [63:0]            r_ang;
	logic [47:0]                   h_sum;
	logic signed [63:0]            p_n;
	logic [63:0]                   p_mag;
	logic [10:0]                   div_r2;
	logic                          div_ge;
	logic signed [48:0]            div_step;
	logic signed [31:0]            acc_sel;
	logic signed [31:0]            acc_new;

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != ddo_pkg::ST_IDLE);
	assign is_cordic = (ph_q == ddo_pkg::PH_ROT) || (ph_q == ddo_pkg::PH_QUAT);
	assign is_div    = (ph_q == ddo_pkg::PH_DIVX) || (ph_q == ddo_pkg::PH_DIVY);
	assign div_start = (state_q == ddo_pkg::ST_CALC) && launch_q && is_div;
	assign div_done  = div_busy_q && (div_cnt_q == '0);
	assign unit_done = mul_done || cres.done || div_done;

	// operand selection per phase
	always_comb begin
		mcmd.start    = (state_q == ddo_pkg::ST_CALC) && launch_q && !is_cordic && !is_div;
		mcmd.b_signed = (ph_q == ddo_pkg::PH_VC) || (ph_q == ddo_pkg::PH_VS);
		mcmd.nbits    = ddo_pkg::MUL_N_W'(16);
		mul_a         = '0;
		mul_b         = '0;
		case (ph_q)
			ddo_pkg::PH_SUMV: begin
				mul_a      = 64'(sum_q);
				mul_b      = sp_q;
				mcmd.nbits = ddo_pkg::MUL_N_W'(24);
			end
			ddo_pkg::PH_DIFV: begin
				mul_a      = 64'(dif_q);
				mul_b      = sp_q;
				mcmd.nbits = ddo_pkg::MUL_N_W'(24);
			end
			ddo_pkg::PH_OMEGA: begin
				mul_a      = 64'(dv_q);
				mul_b      = it_q;
				mcmd.nbits = ddo_pkg::MUL_N_W'(24);
			end
			ddo_pkg::PH_WDT: begin
				mul_a = 64'(w_q);
				mul_b = {8'd0, dt_q};
			end
			ddo_pkg::PH_HEAD: begin
				mul_a      = $signed({16'd0, wdt_q});
				mul_b      = ddo_pkg::HEAD_SCALE;
				mcmd.nbits = ddo_pkg::MUL_N_W'(20);
			end
			ddo_pkg::PH_VC: begin
				mul_a = 64'(v16_q);
				mul_b = {8'd0, c_q};
			end
			ddo_pkg::PH_VS: begin
				mul_a = 64'(v16_q);
				mul_b = {8'd0, s_q};
			end
			ddo_pkg::PH_PX, ddo_pkg::PH_PY: begin
				mul_a = $signed(mul_prod);
				mul_b = {8'd0, dt_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign ccmd.start = (state_q == ddo_pkg::ST_CALC) && launch_q && is_cordic;
	assign ccmd.angle = (ph_q == ddo_pkg::PH_ROT) ? {hd_q, 16'd0} : {1'b0, hd_q, 15'd0};

	ddo_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mcmd),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	ddo_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (ccmd),
		.res    (cres)
	);

	// rounding of the product per phase
	assign p_s   = $signed(mul_prod);
	assign r_v16 = (p_s + 64'sd4096) >>> 13;
	assign r_lin = (p_s + 64'sd65536) >>> 17;
	assign r_dv  = (p_s + 64'sd2048) >>> 12;
	assign r_w   = (p_s + 64'sd32768) >>> 16;
	assign r_ang = (r_w + 64'sd32) >>> 6;
	assign h_sum = mul_prod[47:0] + 48'h0000_8000_0000;
	assign p_n   = (p_s + 64'sd16384000) >>> 15;
	assign p_mag = p_n[63] ? ~p_n : p_n;

	// restoring divide by 1000, one quotient bit a cycle
	assign div_r2   = {div_rem_q, div_num_q[47]};
	assign div_ge   = (div_r2 >= ddo_pkg::DIV_CONST);
	assign div_step = div_neg_q ? ~$signed({1'b0, div_num_q}) : $signed({1'b0, div_num_q});
	assign acc_sel  = (ph_q == ddo_pkg::PH_DIVX) ? acc_x_q : acc_y_q;
	assign acc_new  = ddo_pkg::sat32(50'(acc_sel) + 50'(div_step));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ddo_pkg::ST_IDLE;
			ph_q        <= ddo_pkg::PH_SUMV;
			launch_q    <= 1'b0;
			sp_q        <= ddo_pkg::SPEED_PER_RPM_RST;
			it_q        <= ddo_pkg::INVERSE_TRACK_RST;
			acc_x_q     <= '0;
			acc_y_q     <= '0;
			hd_q        <= '0;
			div_busy_q  <= 1'b0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ddo_pkg::REG_SPEED_PER_RPM: sp_q <= cfg_data;
					ddo_pkg::REG_INVERSE_TRACK: it_q <= cfg_data;
					default: ;
				endcase
			end
			if ((state_q == ddo_pkg::ST_DONE) && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (div_start) begin
				div_busy_q <= 1'b1;
				div_cnt_q  <= 6'd48;
			end else if (div_busy_q) begin
				if (div_cnt_q != '0) begin
					div_cnt_q <= div_cnt_q - 6'd1;
				end else begin
					div_busy_q <= 1'b0;
				end
			end
			case (state_q)
				ddo_pkg::ST_IDLE: begin
					if (in_acc) begin
						state_q  <= ddo_pkg::ST_CALC;
						ph_q     <= ddo_pkg::PH_SUMV;
						launch_q <= 1'b1;
					end
				end
				ddo_pkg::ST_CALC: begin
					if (launch_q) begin
						launch_q <= 1'b0;
					end else if (unit_done) begin
						case (ph_q)
							ddo_pkg::PH_HEAD: hd_q <= hd_q + h_sum[47:32];
							ddo_pkg::PH_DIVX: acc_x_q <= acc_new;
							ddo_pkg::PH_DIVY: acc_y_q <= acc_new;
							default: ;
						endcase
						if (ph_q == ddo_pkg::PH_QUAT) begin
							state_q <= ddo_pkg::ST_DONE;
						end else begin
							ph_q     <= ph_q + 4'd1;
							launch_q <= 1'b1;
						end
					end
				end
				ddo_pkg::ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= ddo_pkg::ST_IDLE;
					end
				end
				default: state_q <= ddo_pkg::ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sum_q <= {left_speed[15], left_speed} + {right_speed[15], right_speed};
			dif_q <= {right_speed[15], right_speed} - {left_speed[15], left_speed};
			dt_q  <= elapsed_ms;
		end
		if (div_start) begin
			div_rem_q <= '0;
		end else if (div_busy_q && (div_cnt_q != '0)) begin
			div_rem_q <= div_ge ? 10'(div_r2 - ddo_pkg::DIV_CONST) : div_r2[9:0];
			div_num_q <= {div_num_q[46:0], div_ge};
		end
		if ((state_q == ddo_pkg::ST_CALC) && !launch_q && unit_done) begin
			case (ph_q)
				ddo_pkg::PH_SUMV: begin
					v16_q <= r_v16[29:0];
					lin_q <= ddo_pkg::sat16(r_lin[47:0]);
				end
				ddo_pkg::PH_DIFV:  dv_q <= r_dv[29:0];
				ddo_pkg::PH_OMEGA: begin
					w_q   <= r_w[39:0];
					ang_q <= ddo_pkg::sat16(r_ang[47:0]);
				end
				ddo_pkg::PH_WDT:   wdt_q <= mul_prod[47:0];
				ddo_pkg::PH_ROT: begin
					c_q <= cres.val.c;
					s_q <= cres.val.s;
				end
				ddo_pkg::PH_PX, ddo_pkg::PH_PY: begin
					div_num_q <= p_mag[47:0];
					div_neg_q <= p_n[63];
				end
				ddo_pkg::PH_QUAT: begin
					qw_q <= cres.val.c;
					qz_q <= cres.val.s;
				end
				default: ;
			endcase
		end
		if ((state_q == ddo_pkg::ST_DONE) && (!out_valid_q || !out_stall)) begin
			o_x_q   <= acc_x_q;
			o_y_q   <= acc_y_q;
			o_hd_q  <= hd_q;
			o_lin_q <= lin_q;
			o_ang_q <= ang_q;
			o_qz_q  <= qz_q;
			o_qw_q  <= qw_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign pos_x       = o_x_q;
	assign pos_y       = o_y_q;
	assign heading_out = o_hd_q;
	assign lin_vel     = o_lin_q;
	assign ang_vel     = o_ang_q;
	assign quat_z      = o_qz_q;
	assign quat_w      = o_qw_q;

endmodule

@@ hdl/ddo_checker.sv @@
// port-level checks of the odometry block, bound to the top level
// uses diff_drive_odometry_defines.svh and ddo_pkg
`include "diff_drive_odometry_defines.svh"

module ddo_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_we,
	input logic                           cfg_index,
	input logic [ddo_pkg::CFG_W-1:0]      cfg_data,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic signed [15:0]             left_speed,
	input logic signed [15:0]             right_speed,
	input logic [15:0]                    elapsed_ms,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic signed [31:0]             pos_x,
	input logic signed [31:0]             pos_y,
	input logic [15:0]                    heading_out,
	input logic signed [15:0]             lin_vel,
	input logic signed [15:0]             ang_vel,
	input logic signed [15:0]             quat_z,
	input logic signed [15:0]             quat_w
);

	// busy after an input transaction
	`DDO_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall)
	// a new result frees the input side
	`DDO_ASSERT_NOW(a_free_on_result, $rose(out_valid), !in_stall)
	// stalled result stays
	`DDO_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`DDO_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
		$stable(pos_x) && $stable(pos_y) && $stable(heading_out) && $stable(quat_w))

endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (.*);
